@@ design/running_mean_variance_stats_core_macros.svh @@
// Assertion macros for the running statistics core.
`ifndef RUNNING_MEAN_VARIANCE_STATS_CORE_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_STATS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rmvs_pkg.sv @@
// Types and constants shared by the running statistics block.
package rmvs_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned AVG_W    = 24;
    localparam int unsigned ACC_W    = 66;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned OPND_W   = 33;
    localparam int unsigned STEP_W   = 7;

    localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = 7'd32;
    localparam logic [STEP_W-1:0] MUL_STEPS      = 7'd32;
    localparam logic [STEP_W-1:0] AVG_DIV_STEPS  = 7'd40;
    localparam logic [STEP_W-1:0] VAR_DIV_STEPS  = 7'd64;
    localparam logic [STEP_W-1:0] ROOT_STEPS     = 7'd32;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_MUL,
        OP_SQRT
    } rmvs_op_t;

    typedef struct packed {
        logic                start;
        rmvs_op_t            op;
        logic [STEP_W-1:0]   steps;
        logic [WORD_W-1:0]   word;
        logic [OPND_W-1:0]   opnd;
    } rmvs_cmd_t;

    typedef struct packed {
        logic                done;
        logic [ACC_W-1:0]    acc;
        logic [WORD_W-1:0]   word;
        logic [OPND_W-1:0]   opnd;
    } rmvs_res_t;

endpackage

@@ design/rmvs_iter.sv @@
// Shared iterative unit: restoring divide, shift-add multiply and square root, one step a cycle.
module rmvs_iter
    import rmvs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rmvs_cmd_t cmd,
    output rmvs_res_t res
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    rmvs_op_t          op_reg;
    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [OPND_W-1:0] opnd_reg, opnd_next;

    logic [ACC_W-1:0]  x;
    logic [ACC_W-1:0]  y;
    logic              sub;
    logic [ACC_W:0]    sum;
    logic              fits;

    always_comb begin
        x         = '0;
        y         = '0;
        sub       = 1'b1;
        acc_next  = acc_reg;
        word_next = word_reg;
        opnd_next = opnd_reg;
        case (op_reg)
            OP_DIV: begin
                x = {acc_reg[ACC_W-2:0], word_reg[WORD_W-1]};
                y = ACC_W'(opnd_reg);
            end
            OP_MUL: begin
                x   = {acc_reg[ACC_W-2:0], 1'b0};
                y   = word_reg[WORD_W-1] ? ACC_W'(opnd_reg) : '0;
                sub = 1'b0;
            end
            OP_SQRT: begin
                x = {acc_reg[ACC_W-3:0], word_reg[WORD_W-1:WORD_W-2]};
                y = {{(ACC_W-OPND_W-2){1'b0}}, opnd_reg, 2'b01};
            end
            default: begin
                x = '0;
            end
        endcase
        sum  = {1'b0, x} + ({1'b0, y} ^ {(ACC_W+1){sub}}) + (ACC_W+1)'(sub);
        fits = !sum[ACC_W];
        case (op_reg)
            OP_DIV: begin
                acc_next  = fits ? sum[ACC_W-1:0] : x;
                word_next = {word_reg[WORD_W-2:0], fits};
            end
            OP_MUL: begin
                acc_next  = sum[ACC_W-1:0];
                word_next = {word_reg[WORD_W-2:0], 1'b0};
            end
            OP_SQRT: begin
                acc_next  = fits ? sum[ACC_W-1:0] : x;
                word_next = {word_reg[WORD_W-3:0], 2'b00};
                opnd_next = {opnd_reg[OPND_W-2:0], fits};
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !cmd.start && (cnt_reg == STEP_W'(1));
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
                op_reg   <= cmd.op;
                acc_reg  <= '0;
                word_reg <= cmd.word;
                opnd_reg <= cmd.opnd;
            end else if (busy_reg) begin
                acc_reg  <= acc_next;
                word_reg <= word_next;
                opnd_reg <= opnd_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.acc  = acc_reg;
    assign res.word = word_reg;
    assign res.opnd = opnd_reg;

endmodule

@@ design/running_mean_variance_stats_core.sv @@
// Running statistics core: count, extremes, Welford mean, average and standard deviation.
// A clear beat skips the shared iterative unit and goes straight to its result.
// A dropped beat or a first sample runs the average divide (40 steps),
// variance divide (64 steps) and square root (32 steps) on the one shared iterative unit.
// A further sample first adds the mean divide and the deviation product (32 steps each).
// One beat is in work at a time. Reset (aresetn low, synchronous) empties the store.
module running_mean_variance_stats_core
    import rmvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // sample
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // sample_count, minimum, maximum, average, std_dev
    output logic [1:0]  m_tuser   // empty_res, dropped
);

`include "running_mean_variance_stats_core_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MDIV,
        S_D2,
        S_MMUL,
        S_ADIV,
        S_QDIV,
        S_ROOT,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic signed [31:0]          total_reg;
    logic signed [SAMPLE_W-1:0]  min_reg;
    logic signed [SAMPLE_W-1:0]  max_reg;
    logic signed [31:0]          mean_reg;
    logic [63:0]                 sq_reg;
    logic signed [31:0]          sf_reg;
    logic                        upd_reg;
    logic                        drop_reg;
    logic                        d1_neg_reg;
    logic [31:0]                 d1_mag_reg;
    logic                        avg_neg_reg;
    logic [AVG_W-1:0]            avg_reg;
    logic [AVG_W-1:0]            sd_reg;
    rmvs_cmd_t                   cmd_reg;
    logic                        m_tvalid_reg;
    logic [95:0]                 m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    rmvs_res_t                   unit;
    logic                        accept;
    logic                        start_next;
    logic signed [SAMPLE_W-1:0]  s;
    logic signed [32:0]          dev;
    logic [31:0]                 dev_mag;
    logic [31:0]                 tot_mag;
    logic signed [31:0]          mean_upd;
    logic [64:0]                 q_sum;
    logic [63:0]                 q_new;
    logic [39:0]                 avg_q;
    logic [AVG_W-1:0]            avg_sat;
    logic [AVG_W-1:0]            sd_sat;

    rmvs_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_reg),
        .res     (unit)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign s        = s_tdata;

    always_comb begin
        case (state_reg)
            S_START: begin
                start_next = upd_reg || (count_reg != '0);
            end
            S_D2: begin
                start_next = 1'b1;
            end
            S_MMUL, S_ADIV, S_QDIV: begin
                start_next = unit.done;
            end
            default: begin
                start_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        dev      = 33'(sf_reg) - 33'(mean_reg);
        dev_mag  = dev[32] ? 32'(-dev) : dev[31:0];
        tot_mag  = total_reg[31] ? 32'(-total_reg) : 32'(total_reg);
        mean_upd = d1_neg_reg ? mean_reg - $signed(unit.word[31:0])
                              : mean_reg + $signed(unit.word[31:0]);
        q_sum    = {1'b0, sq_reg} + 65'(unit.acc[63:FRAC_W]);
        q_new    = q_sum[64] ? '1 : q_sum[63:0];
        avg_q    = unit.word[39:0];
        if (!avg_neg_reg) begin
            avg_sat = (avg_q > 40'h7FFFFF) ? 24'h7FFFFF : avg_q[AVG_W-1:0];
        end else begin
            avg_sat = (avg_q > 40'h800000) ? 24'h800000 : AVG_W'(-avg_q[AVG_W-1:0]);
        end
        sd_sat   = (|unit.opnd[31:AVG_W]) ? '1 : unit.opnd[AVG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            upd_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            cmd_reg.start <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cmd_reg.start <= start_next;
            if (m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        upd_reg   <= !s_tuser && (count_reg != '1) && (count_reg != '0);
                        drop_reg  <= !s_tuser && (count_reg == '1);
                        state_reg <= S_START;
                        if (s_tuser) begin
                            count_reg <= '0;
                            total_reg <= '0;
                            min_reg   <= '0;
                            max_reg   <= '0;
                            mean_reg  <= '0;
                            sq_reg    <= '0;
                        end else if (count_reg == '0) begin
                            count_reg <= COUNT_W'(1);
                            total_reg <= 32'(s);
                            min_reg   <= s;
                            max_reg   <= s;
                            mean_reg  <= {s, 16'b0};
                            sq_reg    <= '0;
                        end else if (count_reg != '1) begin
                            count_reg <= count_reg + 1'b1;
                            total_reg <= total_reg + 32'(s);
                            if (s < min_reg) begin
                                min_reg <= s;
                            end
                            if (s > max_reg) begin
                                max_reg <= s;
                            end
                            sf_reg  <= {s, 16'b0};
                        end
                    end
                end
                S_START: begin
                    if (upd_reg) begin
                        d1_neg_reg    <= dev[32];
                        d1_mag_reg    <= dev_mag;
                        cmd_reg.op    <= OP_DIV;
                        cmd_reg.steps <= MEAN_DIV_STEPS;
                        cmd_reg.word  <= {dev_mag, 32'b0};
                        cmd_reg.opnd  <= OPND_W'(count_reg);
                        state_reg     <= S_MDIV;
                    end else if (count_reg != '0) begin
                        avg_neg_reg   <= total_reg[31];
                        cmd_reg.op    <= OP_DIV;
                        cmd_reg.steps <= AVG_DIV_STEPS;
                        cmd_reg.word  <= {tot_mag, 8'b0, 24'b0};
                        cmd_reg.opnd  <= OPND_W'(count_reg);
                        state_reg     <= S_ADIV;
                    end else begin
                        avg_reg   <= '0;
                        sd_reg    <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_MDIV: begin
                    if (unit.done) begin
                        mean_reg  <= mean_upd;
                        state_reg <= S_D2;
                    end
                end
                S_D2: begin
                    cmd_reg.op    <= OP_MUL;
                    cmd_reg.steps <= MUL_STEPS;
                    cmd_reg.word  <= {dev_mag, 32'b0};
                    cmd_reg.opnd  <= {1'b0, d1_mag_reg};
                    state_reg     <= S_MMUL;
                end
                S_MMUL: begin
                    if (unit.done) begin
                        sq_reg        <= q_new;
                        avg_neg_reg   <= total_reg[31];
                        cmd_reg.op    <= OP_DIV;
                        cmd_reg.steps <= AVG_DIV_STEPS;
                        cmd_reg.word  <= {tot_mag, 8'b0, 24'b0};
                        cmd_reg.opnd  <= OPND_W'(count_reg);
                        state_reg     <= S_ADIV;
                    end
                end
                S_ADIV: begin
                    if (unit.done) begin
                        avg_reg       <= avg_sat;
                        cmd_reg.op    <= OP_DIV;
                        cmd_reg.steps <= VAR_DIV_STEPS;
                        cmd_reg.word  <= sq_reg;
                        cmd_reg.opnd  <= OPND_W'(count_reg);
                        state_reg     <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (unit.done) begin
                        cmd_reg.op    <= OP_SQRT;
                        cmd_reg.steps <= ROOT_STEPS;
                        cmd_reg.word  <= unit.word;
                        cmd_reg.opnd  <= '0;
                        state_reg     <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (unit.done) begin
                        sd_reg    <= sd_sat;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {sd_reg, avg_reg, max_reg, min_reg, count_reg};
                        m_tuser_reg  <= {drop_reg, count_reg == '0};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RMVS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready, "ready after accept")
    `RMVS_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 96'd0, "empty result not zero")
    `RMVS_ASSERT_NOW(a_drop_full, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[15:0] == 16'hFFFF, "drop below full")
    `RMVS_ASSERT_NOW(a_no_start_idle, aclk, aresetn, cmd_reg.start, state_reg != S_IDLE, "unit started while idle")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the running statistics core with a built-in predictor.
module testbench;
    import rmvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_FULL = (1 << COUNT_W) - 1;
    localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct {
        logic [COUNT_W-1:0]         sample_count;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [AVG_W-1:0]    average;
        logic [23:0]                std_dev;
        logic                       empty_res;
        logic                       dropped;
    } stats_t;

    class stats_scoreboard;
        longint unsigned n_samples;
        longint          sum;
        longint          lowest;
        longint          highest;
        longint          mean_fx;
        longint unsigned sq_dev;
        stats_t          pending_q[$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            empty_store();
        endfunction

        function void empty_store();
            n_samples = 0;
            sum = 0;
            lowest = 0;
            highest = 0;
            mean_fx = 0;
            sq_dev = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function void add_sample(longint s);
            longint          sf;
            longint          d1;
            longint          d2;
            logic [127:0]    wide;
            longint unsigned prod;
            logic [64:0]     acc;
            sf = s * 65536;
            if (n_samples == 0) begin
                n_samples = 1;
                sum = s;
                lowest = s;
                highest = s;
                mean_fx = sf;
                sq_dev = 0;
                return;
            end
            n_samples++;
            sum += s;
            if (s < lowest) lowest = s;
            if (s > highest) highest = s;
            d1 = sf - mean_fx;
            mean_fx = mean_fx + d1 / longint'(n_samples);
            d2 = sf - mean_fx;
            wide = 128'((d1 < 0) ? -d1 : d1) * 128'((d2 < 0) ? -d2 : d2);
            if (wide > 128'(64'hFFFF_FFFF_FFFF_FFFF)) prod = 64'hFFFF_FFFF_FFFF_FFFF;
            else prod = wide[63:0];
            prod = prod >> FRAC_W;
            acc = 65'(sq_dev) + 65'(prod);
            sq_dev = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        endfunction

        function void note_beat(logic kind, logic signed [SAMPLE_W-1:0] sample);
            stats_t          e;
            longint          q;
            longint          r;
            longint          avg;
            longint unsigned sd;
            e.dropped = 1'b0;
            if (kind == KIND_CLEAR) empty_store();
            else if (n_samples >= COUNT_FULL) e.dropped = 1'b1;
            else add_sample(longint'(sample));
            avg = 0;
            sd = 0;
            if (n_samples != 0) begin
                q = sum / longint'(n_samples);
                r = sum % longint'(n_samples);
                avg = q * 256 + (r * 256) / longint'(n_samples);
                if (avg > 64'sd8388607) avg = 64'sd8388607;
                if (avg < -64'sd8388608) avg = -64'sd8388608;
                sd = int_sqrt(sq_dev / n_samples);
                if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;
            end
            e.sample_count = n_samples[COUNT_W-1:0];
            e.minimum = (n_samples != 0) ? lowest[SAMPLE_W-1:0] : '0;
            e.maximum = (n_samples != 0) ? highest[SAMPLE_W-1:0] : '0;
            e.average = avg[AVG_W-1:0];
            e.std_dev = sd[23:0];
            e.empty_res = (n_samples == 0);
            pending_q.push_back(e);
        endfunction

        function void check_beat(logic [95:0] data, logic [1:0] user);
            stats_t e;
            stats_t a;
            a.sample_count = data[15:0];
            a.minimum = data[31:16];
            a.maximum = data[47:32];
            a.average = data[71:48];
            a.std_dev = data[95:72];
            a.empty_res = user[0];
            a.dropped = user[1];
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: data %h user %b", data, user);
                return;
            end
            e = pending_q.pop_front();
            if (a.sample_count !== e.sample_count || a.minimum !== e.minimum ||
                a.maximum !== e.maximum || a.average !== e.average ||
                a.std_dev !== e.std_dev || a.empty_res !== e.empty_res ||
                a.dropped !== e.dropped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cnt %0d min %0d max %0d avg %0d sd %0d e %b d %b,",
                        e.sample_count, e.minimum, e.maximum, e.average, e.std_dev,
                        e.empty_res, e.dropped,
                        " got cnt %0d min %0d max %0d avg %0d sd %0d e %b d %b",
                        a.sample_count, a.minimum, a.maximum,
                        a.average, a.std_dev, a.empty_res, a.dropped);
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    stats_scoreboard stats_sb;
    longint unsigned cycle_count;
    bit              ready_always;
    int unsigned     burst_left;

    running_mean_variance_stats_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver alternates between stretches of steady acceptance and random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) stats_sb.check_beat(m_tdata, m_tuser);
        if (cycle_count % 3000 == 0) ready_always <= ($urandom_range(0, 2) == 0);
        m_tready <= ready_always || ($urandom_range(0, 3) != 0);
    end

    task automatic send_beat(logic kind, logic [15:0] sample);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= sample;
        do @(posedge aclk); while (!s_tready);
        stats_sb.note_beat(kind, sample);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        stats_sb = new();
        cycle_count = 0;
        ready_always = 1'b1;
        burst_left = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        m_tready <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty store, extremes, clears and a seeded first sample.
        send_beat(KIND_CLEAR, 16'h0000);
        send_beat(KIND_CLEAR, 16'hFFFF);
        send_beat(KIND_RECORD, 16'h8000);
        send_beat(KIND_RECORD, 16'h7FFF);
        send_beat(KIND_RECORD, 16'h8000);
        send_beat(KIND_RECORD, 16'h7FFF);
        send_beat(KIND_RECORD, 16'h0000);
        send_beat(KIND_RECORD, 16'hFFFF);
        send_beat(KIND_CLEAR, 16'h7FFF);
        send_beat(KIND_RECORD, 16'h7FFF);
        send_beat(KIND_RECORD, 16'h7FFF);
        send_beat(KIND_RECORD, 16'h7FFE);
        send_beat(KIND_CLEAR, 16'h0000);
        send_beat(KIND_RECORD, 16'hFFFF);
        send_beat(KIND_RECORD, 16'h0001);
        send_beat(KIND_RECORD, 16'h5555);
        send_beat(KIND_RECORD, 16'hAAAA);

        // The sender holds off until every outstanding result has drained.
        s_tvalid <= 1'b0;
        while (stats_sb.outstanding() != 0) @(posedge aclk);

        // Random part: mostly sample runs of varied length split by clears.
        for (int i = 0; i < 1350; i++) begin
            if ($urandom_range(0, 24) == 0) send_beat(KIND_CLEAR, 16'($urandom));
            else send_beat(KIND_RECORD, random_sample());
        end

        send_beat(KIND_CLEAR, 16'h0000);
        send_beat(KIND_RECORD, 16'h1234);
        s_tvalid <= 1'b0;

        while (stats_sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (stats_sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/rmvs_pkg.sv
design/rmvs_iter.sv
design/running_mean_variance_stats_core.sv
dv/testbench.sv
